>>> rtl/upa_pkg.sv
// Shared types and constants for the ultrasonic proximity alarm.
// No dependencies; the RTL files that use it refer to it by scoped names, the test files import it.
`default_nettype none

package upa_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_WIDTH    = 3'd0,
    CFG_ECHO_TIMEOUT  = 3'd1,
    CFG_MEASURE_GAP   = 3'd2,
    CFG_BURST_TOGGLES = 3'd3,
    CFG_BURST_PAUSE   = 3'd4,
    CFG_SILENT_PAUSE  = 3'd5
  } cfg_idx_t;

  // Field and state widths
  localparam int TRIG_W  = 8;
  localparam int TOUT_W  = 16;
  localparam int CNT_W   = 18;
  localparam int TOG_W   = 6;
  localparam int WIDTH_W = 16;
  localparam int TONE_W  = 10;
  localparam int HALF_W  = 12;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST    = 8'd10;
  localparam logic [TOUT_W-1:0] ECHO_TIMEOUT_RST  = 16'd30000;
  localparam logic [CNT_W-1:0]  MEASURE_GAP_RST   = 18'd150000;
  localparam logic [TOG_W-1:0]  BURST_TOGGLES_RST = 6'd40;
  localparam logic [CNT_W-1:0]  BURST_PAUSE_RST   = 18'd10000;
  localparam logic [CNT_W-1:0]  SILENT_PAUSE_RST  = 18'd100000;

  // Divider: 20-bit dividend, 10-bit divisor, two quotient bits per cycle
  localparam int DVD_W     = 20;
  localparam int DSR_W     = 10;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Width to tone mapping: (TONE_NUM - TONE_K*w) / 1000 for 0 < w <= WIDTH_MAX;
  // the divide is a multiply by TONE_RECIP = ceil(2^TONE_SHIFT / 1000) and a shift
  localparam logic [DVD_W-1:0]   TONE_NUM   = 20'd800000;
  localparam logic [DVD_W-1:0]   TONE_K     = 20'd686;
  localparam logic [DVD_W-1:0]   TONE_RECIP = 20'd536871;
  localparam int                 TONE_SHIFT = 29;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 16'd874;
  localparam logic [DVD_W-1:0]   HALF_NUM   = 20'd500000;

  typedef struct packed {
    logic range_step;   // run one tick of the ranging unit, latch echo result
    logic tone_prep;    // register the tone dividend
    logic div_start;    // launch the half-period division
    logic tone_load;    // capture the reciprocal product as latest tone
    logic half_load;    // capture divider quotient as latest half period
    logic tone_step;    // run one tick of the tone unit, load output register
  } upa_cmd_t;

  typedef struct packed {
    logic meas_done;    // ranging tick in progress completes a measurement
    logic div_busy;
    logic div_done;
  } upa_stat_t;

endpackage

`default_nettype wire

>>> rtl/upa_in_if.sv
// Input channel: one microsecond tick with the sampled echo level.
// Depends on nothing.
`default_nettype none

interface upa_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

>>> rtl/upa_out_if.sv
// Result channel: pin levels and measurement status for one tick.
// Depends on upa_pkg for field widths.
`default_nettype none

interface upa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          trigger_out;
  logic                          alarm_out;
  logic                          measure_done;
  logic [upa_pkg::WIDTH_W-1:0]   echo_width_us;
  logic [upa_pkg::TONE_W-1:0]    tone_hz;

  modport source (output valid, output trigger_out, output alarm_out, output measure_done,
                  output echo_width_us, output tone_hz, input ready);
  modport sink   (input valid, input trigger_out, input alarm_out, input measure_done,
                  input echo_width_us, input tone_hz, output ready);
endinterface

`default_nettype wire

>>> rtl/upa_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on upa_pkg for widths.
`default_nettype none

interface upa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [upa_pkg::CFG_IDX_W-1:0]    index;
  logic [upa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ultrasonic_proximity_alarm.sv
// Top level of the ultrasonic proximity alarm: sequencer plus datapath.
// Depends on upa_pkg, upa_in_if, upa_out_if, upa_cfg_if, upa_ctrl, upa_datapath.
//
//  channel  dir  payload                                          handshake
//  in_ch    in   echo_level                                       valid/ready
//  out_ch   out  trigger_out alarm_out measure_done               valid/ready
//                echo_width_us tone_hz
//  cfg_ch   in   index data                                       valid/ready
//
// A tick without a completed measurement is accepted, then the tone-unit step
// loads the result register. A tick that completes a measurement first gets its
// tone (registered dividend, then reciprocal multiply) and then runs the ten
// steps of the 2-bit-per-cycle half-period divider. rst_n is synchronous;
// all config registers return to their defaults. A stalled result holds the
// sequencer in its last step, and no new tick is taken until that step is done.
`default_nettype none

module ultrasonic_proximity_alarm (
  input  wire logic  clk,
  input  wire logic  rst_n,
  upa_in_if.sink     in_ch,
  upa_out_if.source  out_ch,
  upa_cfg_if.sink    cfg_ch
);

  upa_pkg::upa_cmd_t  cmd;
  upa_pkg::upa_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  upa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  upa_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .echo_level    (in_ch.echo_level),
    .cmd           (cmd),
    .stat          (stat),
    .trigger_out   (out_ch.trigger_out),
    .alarm_out     (out_ch.alarm_out),
    .measure_done  (out_ch.measure_done),
    .echo_width_us (out_ch.echo_width_us),
    .tone_hz       (out_ch.tone_hz)
  );

  // trigger phase and measurement completion never share a tick
  a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.trigger_out && out_ch.measure_done))
    else $error("trigger and measure_done both set");

  // a timeout or missing echo must map to silence
  a_zero_width_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.measure_done && out_ch.echo_width_us == '0)
      |-> (out_ch.tone_hz == '0))
    else $error("zero echo width produced a tone");

  a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.tone_hz <= 10'd800))
    else $error("tone out of range");

  // the divider is only launched when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

>>> rtl/upa_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
// Depends on upa_pkg for operand widths and step count.
`default_nettype none

module upa_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [upa_pkg::DVD_W-1:0]   dividend,
  input  wire logic [upa_pkg::DSR_W-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [upa_pkg::DVD_W-1:0]        quotient
);

  localparam int DVD_W = upa_pkg::DVD_W;
  localparam int DSR_W = upa_pkg::DSR_W;

  logic                         busy_r;
  logic                         done_r;
  logic [upa_pkg::STEP_W-1:0]   step_r;
  logic [DVD_W-1:0]             dq_r, dq_nxt;
  logic [DSR_W-1:0]             rem_r, rem_nxt;
  logic [DSR_W-1:0]             dsr_r;
  logic [DSR_W:0]               s1, s2;

  // returns {quotient bit, new remainder}
  function automatic logic [DSR_W:0] div_step(input logic [DSR_W-1:0] rem,
                                              input logic nb,
                                              input logic [DSR_W-1:0] dsr);
    logic [DSR_W:0] trial;
    logic [DSR_W:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      return {1'b1, diff[DSR_W-1:0]};
    end
    return {1'b0, trial[DSR_W-1:0]};
  endfunction

  always_comb begin
    s1      = div_step(rem_r, dq_r[DVD_W-1], dsr_r);
    s2      = div_step(s1[DSR_W-1:0], dq_r[DVD_W-2], dsr_r);
    rem_nxt = s2[DSR_W-1:0];
    dq_nxt  = {dq_r[DVD_W-3:0], s1[DSR_W], s2[DSR_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dq_r   <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        if (step_r == upa_pkg::STEP_W'(upa_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dq_r;

endmodule

`default_nettype wire

>>> rtl/upa_ctrl.sv
// Sequencer: accepts ticks, runs the tone and half-period computation after a
// measurement, and hands finished results to the output register. Depends on upa_pkg.
`default_nettype none

module upa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire upa_pkg::upa_stat_t stat,
  output upa_pkg::upa_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE_PREP,
    S_TONE_LOAD,
    S_DIV_HALF,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.range_step = 1'b1;
          state_nxt      = stat.meas_done ? S_TONE_PREP : S_FINISH;
        end
      end
      S_TONE_PREP: begin
        cmd.tone_prep = 1'b1;
        state_nxt     = S_TONE_LOAD;
      end
      S_TONE_LOAD: begin
        // tone is ready; it is also the divisor of the half-period division
        cmd.tone_load = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_HALF;
      end
      S_DIV_HALF: begin
        if (stat.div_done) begin
          cmd.half_load = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.tone_step = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.tone_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/upa_datapath.sv
// Datapath: configuration registers, ranging counters, tone unit,
// half-period divider and the result payload register. Depends on upa_pkg, upa_div.
`default_nettype none

module upa_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [upa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [upa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           echo_level,
  input  wire upa_pkg::upa_cmd_t              cmd,
  output upa_pkg::upa_stat_t                  stat,
  output logic                                trigger_out,
  output logic                                alarm_out,
  output logic                                measure_done,
  output logic [upa_pkg::WIDTH_W-1:0]         echo_width_us,
  output logic [upa_pkg::TONE_W-1:0]          tone_hz
);

  localparam int CNT_W   = upa_pkg::CNT_W;
  localparam int WIDTH_W = upa_pkg::WIDTH_W;
  localparam int TONE_W  = upa_pkg::TONE_W;
  localparam int HALF_W  = upa_pkg::HALF_W;
  localparam int TOG_W   = upa_pkg::TOG_W;
  localparam int DVD_W   = upa_pkg::DVD_W;

  typedef enum logic [1:0] {PH_TRIG, PH_RISE, PH_FALL, PH_GAP} range_ph_t;
  typedef enum logic [1:0] {TP_WAIT, TP_BURST, TP_BPAUSE, TP_SPAUSE} tone_ph_t;

  // configuration
  logic [upa_pkg::TRIG_W-1:0] trig_width_r;
  logic [upa_pkg::TOUT_W-1:0] echo_timeout_r;
  logic [CNT_W-1:0]           measure_gap_r;
  logic [TOG_W-1:0]           burst_toggles_r;
  logic [CNT_W-1:0]           burst_pause_r;
  logic [CNT_W-1:0]           silent_pause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_width_r    <= upa_pkg::TRIG_WIDTH_RST;
      echo_timeout_r  <= upa_pkg::ECHO_TIMEOUT_RST;
      measure_gap_r   <= upa_pkg::MEASURE_GAP_RST;
      burst_toggles_r <= upa_pkg::BURST_TOGGLES_RST;
      burst_pause_r   <= upa_pkg::BURST_PAUSE_RST;
      silent_pause_r  <= upa_pkg::SILENT_PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        upa_pkg::CFG_TRIG_WIDTH:    trig_width_r    <= cfg_data[upa_pkg::TRIG_W-1:0];
        upa_pkg::CFG_ECHO_TIMEOUT:  echo_timeout_r  <= cfg_data[upa_pkg::TOUT_W-1:0];
        upa_pkg::CFG_MEASURE_GAP:   measure_gap_r   <= cfg_data[CNT_W-1:0];
        upa_pkg::CFG_BURST_TOGGLES: burst_toggles_r <= cfg_data[TOG_W-1:0];
        upa_pkg::CFG_BURST_PAUSE:   burst_pause_r   <= cfg_data[CNT_W-1:0];
        upa_pkg::CFG_SILENT_PAUSE:  silent_pause_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- ranging unit ----------------
  range_ph_t          range_phase_r, range_phase_nxt;
  logic [CNT_W-1:0]   range_count_r, range_count_nxt;
  logic [CNT_W:0]     cnt_inc;
  logic [WIDTH_W-1:0] rise_time_r, rise_time_nxt;
  logic [WIDTH_W-1:0] last_width_r, last_width_nxt;
  logic               trig_c, done_c;
  logic               trig_r, meas_done_r;

  always_comb begin
    range_phase_nxt = range_phase_r;
    range_count_nxt = range_count_r;
    rise_time_nxt   = rise_time_r;
    last_width_nxt  = last_width_r;
    trig_c          = 1'b0;
    done_c          = 1'b0;

    if (range_phase_nxt == PH_GAP && range_count_nxt >= measure_gap_r) begin
      range_phase_nxt = PH_TRIG;
      range_count_nxt = '0;
    end
    cnt_inc = {1'b0, range_count_nxt} + 1'b1;

    case (range_phase_nxt)
      PH_TRIG: begin
        trig_c = 1'b1;
        if (cnt_inc >= (CNT_W+1)'(trig_width_r)) begin
          range_phase_nxt = PH_RISE;
          range_count_nxt = '0;
        end else begin
          range_count_nxt = cnt_inc[CNT_W-1:0];
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          rise_time_nxt   = range_count_nxt[WIDTH_W-1:0];
          range_phase_nxt = PH_FALL;
          range_count_nxt = cnt_inc[CNT_W-1:0];
        end else if (cnt_inc >= (CNT_W+1)'(echo_timeout_r)) begin
          last_width_nxt = '0;
          done_c         = 1'b1;
        end else begin
          range_count_nxt = cnt_inc[CNT_W-1:0];
        end
      end
      PH_FALL: begin
        if (!echo_level) begin
          last_width_nxt = range_count_nxt[WIDTH_W-1:0] - rise_time_r;
          done_c         = 1'b1;
        end else if (cnt_inc >= (CNT_W+1)'(echo_timeout_r)) begin
          last_width_nxt = '0;
          done_c         = 1'b1;
        end else begin
          range_count_nxt = cnt_inc[CNT_W-1:0];
        end
      end
      default: range_count_nxt = cnt_inc[CNT_W-1:0];
    endcase

    if (done_c) begin
      range_phase_nxt = PH_GAP;
      range_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_phase_r <= PH_TRIG;
      range_count_r <= '0;
      rise_time_r   <= '0;
      last_width_r  <= '0;
      trig_r        <= 1'b0;
      meas_done_r   <= 1'b0;
    end else if (cmd.range_step) begin
      range_phase_r <= range_phase_nxt;
      range_count_r <= range_count_nxt;
      rise_time_r   <= rise_time_nxt;
      last_width_r  <= last_width_nxt;
      trig_r        <= trig_c;
      meas_done_r   <= done_c;
    end
  end

  // ---------------- tone computation ----------------
  logic                  width_ok;
  logic [DVD_W-1:0]      width_prod;
  logic [DVD_W-1:0]      tone_dividend;
  logic [DVD_W-1:0]      tone_num_r;
  logic [2*DVD_W-1:0]    tone_prod;
  logic [TONE_W-1:0]     tone_calc;
  logic [DVD_W-1:0]      quotient;
  logic                  div_busy, div_done;
  logic [TONE_W-1:0]     latest_tone_r;
  logic [HALF_W-1:0]     latest_half_r;

  assign width_ok      = (last_width_r != '0) && (last_width_r <= upa_pkg::WIDTH_MAX);
  assign width_prod    = upa_pkg::TONE_K * DVD_W'(last_width_r[TONE_W-1:0]);
  assign tone_dividend = width_ok ? (upa_pkg::TONE_NUM - width_prod) : '0;

  // divide by 1000 as a multiply by the rounded-up reciprocal; exact for any 20-bit dividend
  assign tone_prod = {{DVD_W{1'b0}}, tone_num_r} * {{DVD_W{1'b0}}, upa_pkg::TONE_RECIP};
  assign tone_calc = tone_prod[upa_pkg::TONE_SHIFT +: TONE_W];

  // half period = 500000 / tone; the quotient is junk for tone 0 but never used then
  upa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (upa_pkg::HALF_NUM),
    .divisor  (tone_calc),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_num_r    <= '0;
      latest_tone_r <= '0;
      latest_half_r <= '0;
    end else begin
      if (cmd.tone_prep) begin
        tone_num_r <= tone_dividend;
      end
      if (cmd.tone_load) begin
        latest_tone_r <= tone_calc;
      end
      if (cmd.half_load) begin
        latest_half_r <= (quotient[HALF_W-1:0] == '0) ? HALF_W'(1) : quotient[HALF_W-1:0];
      end
    end
  end

  // ---------------- tone unit ----------------
  tone_ph_t          tone_phase_r, tone_phase_nxt;
  logic [CNT_W-1:0]  tone_count_r, tone_count_nxt;
  logic [CNT_W:0]    tcnt_inc;
  logic [TOG_W-1:0]  toggles_r, toggles_nxt;
  logic [HALF_W-1:0] half_period_r, half_period_nxt;
  logic              alarm_r, alarm_nxt;
  logic              take;
  logic [CNT_W-1:0]  pause_len;

  always_comb begin
    tone_phase_nxt  = tone_phase_r;
    tone_count_nxt  = tone_count_r;
    toggles_nxt     = toggles_r;
    half_period_nxt = half_period_r;
    alarm_nxt       = alarm_r;
    take            = 1'b0;
    tcnt_inc        = {1'b0, tone_count_r} + 1'b1;
    pause_len       = (tone_phase_r == TP_BPAUSE) ? burst_pause_r : silent_pause_r;

    case (tone_phase_r)
      TP_WAIT: take = meas_done_r;
      TP_BURST: begin
        if (tcnt_inc >= (CNT_W+1)'(half_period_r)) begin
          tone_count_nxt = '0;
          if (toggles_r >= burst_toggles_r) begin
            tone_phase_nxt = TP_BPAUSE;
          end else begin
            alarm_nxt   = ~alarm_r;
            toggles_nxt = toggles_r + 1'b1;
          end
        end else begin
          tone_count_nxt = tcnt_inc[CNT_W-1:0];
        end
      end
      default: begin
        if (tone_count_r >= pause_len) begin
          take = 1'b1;
        end else begin
          tone_count_nxt = tcnt_inc[CNT_W-1:0];
        end
      end
    endcase

    if (take) begin
      tone_count_nxt = '0;
      if (latest_tone_r != '0) begin
        half_period_nxt = latest_half_r;
        alarm_nxt       = ~alarm_r;
        toggles_nxt     = TOG_W'(1);
        tone_phase_nxt  = TP_BURST;
      end else begin
        alarm_nxt      = 1'b0;
        tone_phase_nxt = TP_SPAUSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_phase_r  <= TP_WAIT;
      tone_count_r  <= '0;
      toggles_r     <= '0;
      half_period_r <= '0;
      alarm_r       <= 1'b0;
    end else if (cmd.tone_step) begin
      tone_phase_r  <= tone_phase_nxt;
      tone_count_r  <= tone_count_nxt;
      toggles_r     <= toggles_nxt;
      half_period_r <= half_period_nxt;
      alarm_r       <= alarm_nxt;
    end
  end

  // ---------------- result register ----------------
  logic               out_trig_r, out_alarm_r, out_done_r;
  logic [WIDTH_W-1:0] out_width_r;
  logic [TONE_W-1:0]  out_tone_r;

  always_ff @(posedge clk) begin
    if (cmd.tone_step) begin
      out_trig_r  <= trig_r;
      out_alarm_r <= alarm_nxt;
      out_done_r  <= meas_done_r;
      out_width_r <= last_width_r;
      out_tone_r  <= latest_tone_r;
    end
  end

  assign trigger_out   = out_trig_r;
  assign alarm_out     = out_alarm_r;
  assign measure_done  = out_done_r;
  assign echo_width_us = out_width_r;
  assign tone_hz       = out_tone_r;

  always_comb begin
    stat.meas_done = done_c;
    stat.div_busy  = div_busy;
    stat.div_done  = div_done;
  end

endmodule

`default_nettype wire

>>> test/ultrasonic_proximity_alarm_checker.sv
// Result checker for the ultrasonic proximity alarm: tracks ranging and tone state per tick.
// Depends on upa_pkg and the upa_in_if, upa_out_if and upa_cfg_if interfaces.
`timescale 1ns / 1ps

module ultrasonic_proximity_alarm_checker (
  input  logic clk,
  input  logic rst_n,
  upa_in_if    in_mon,
  upa_out_if   out_mon,
  upa_cfg_if   cfg_mon,
  output int   pending_results,
  output int   failures
);
  import upa_pkg::*;

  typedef struct packed {
    logic               trigger;
    logic               alarm;
    logic               done;
    logic [WIDTH_W-1:0] width;
    logic [TONE_W-1:0]  tone;
  } pin_result_t;

  typedef enum logic [1:0] {
    RNG_TRIGGER, RNG_RISE_WAIT, RNG_FALL_WAIT, RNG_GAP
  } range_phase_t;

  typedef enum logic [1:0] {
    TONE_IDLE, TONE_BURST, TONE_BURST_PAUSE, TONE_SILENT_PAUSE
  } tone_phase_t;

  // register copies
  logic [TRIG_W-1:0]  trig_width;
  logic [TOUT_W-1:0]  echo_timeout;
  logic [CNT_W-1:0]   meas_gap;
  logic [TOG_W-1:0]   burst_count;
  logic [CNT_W-1:0]   burst_pause;
  logic [CNT_W-1:0]   silent_pause;

  // ranging and tone state
  range_phase_t       rng_phase;
  logic [CNT_W-1:0]   rng_count;
  logic [WIDTH_W-1:0] rise_at;
  logic [WIDTH_W-1:0] width_last;
  logic [TONE_W-1:0]  tone_last;
  tone_phase_t        tn_phase;
  logic [CNT_W-1:0]   tn_count;
  logic [TOG_W-1:0]   toggles;
  logic [HALF_W-1:0]  half_per;
  logic               alarm;

  pin_result_t expected_pins[$];
  int          errors;
  int          results_seen;

  function automatic logic [TONE_W-1:0] tone_for_width(input logic [WIDTH_W-1:0] w);
    int unsigned num;
    logic [TONE_W-1:0] hz;
    if (w == 0 || w > 874) return '0;
    num = 800000 - 686 * w;
    hz = num / 1000;
    return hz;
  endfunction

  // start a burst on the newest tone, or go silent on tone zero
  task automatic take_latest_tone();
    int unsigned q;
    tn_count = '0;
    if (tone_last != 0) begin
      q = 500000 / tone_last;
      half_per = q[HALF_W-1:0];
      if (half_per == 0) half_per = 1;
      alarm = ~alarm;
      toggles = 1;
      tn_phase = TONE_BURST;
    end else begin
      alarm = 1'b0;
      tn_phase = TONE_SILENT_PAUSE;
    end
  endtask

  task automatic predict_tick(input logic echo);
    logic trig, done;
    int unsigned cnt_next, pause_len;
    pin_result_t r;
    trig = 1'b0;
    done = 1'b0;
    if (rng_phase == RNG_GAP && rng_count >= meas_gap) begin
      rng_phase = RNG_TRIGGER;
      rng_count = '0;
    end
    cnt_next = rng_count;
    cnt_next = cnt_next + 1;
    case (rng_phase)
      RNG_TRIGGER: begin
        trig = 1'b1;
        rng_count = rng_count + 1;
        if (rng_count >= trig_width) begin
          rng_phase = RNG_RISE_WAIT;
          rng_count = '0;
        end
      end
      RNG_RISE_WAIT: begin
        if (echo) begin
          rise_at = rng_count[WIDTH_W-1:0];
          rng_phase = RNG_FALL_WAIT;
          rng_count = rng_count + 1;
        end else if (cnt_next >= echo_timeout) begin
          width_last = '0;
          done = 1'b1;
        end else begin
          rng_count = rng_count + 1;
        end
      end
      RNG_FALL_WAIT: begin
        if (!echo) begin
          width_last = rng_count[WIDTH_W-1:0] - rise_at;
          done = 1'b1;
        end else if (cnt_next >= echo_timeout) begin
          width_last = '0;
          done = 1'b1;
        end else begin
          rng_count = rng_count + 1;
        end
      end
      default: rng_count = rng_count + 1;
    endcase
    if (done) begin
      tone_last = tone_for_width(width_last);
      rng_phase = RNG_GAP;
      rng_count = '0;
    end

    case (tn_phase)
      TONE_IDLE: begin
        if (done) take_latest_tone();
      end
      TONE_BURST: begin
        tn_count = tn_count + 1;
        if (tn_count >= half_per) begin
          tn_count = '0;
          if (toggles >= burst_count) begin
            tn_phase = TONE_BURST_PAUSE;
          end else begin
            alarm = ~alarm;
            toggles = toggles + 1;
          end
        end
      end
      default: begin
        pause_len = (tn_phase == TONE_BURST_PAUSE) ? burst_pause : silent_pause;
        if (tn_count >= pause_len) take_latest_tone();
        else tn_count = tn_count + 1;
      end
    endcase

    r.trigger = trig;
    r.alarm   = alarm;
    r.done    = done;
    r.width   = width_last;
    r.tone    = tone_last;
    expected_pins.push_back(r);
  endtask

  always @(posedge clk) begin
    pin_result_t exp_r;
    if (!rst_n) begin
      trig_width   = TRIG_WIDTH_RST;
      echo_timeout = ECHO_TIMEOUT_RST;
      meas_gap     = MEASURE_GAP_RST;
      burst_count  = BURST_TOGGLES_RST;
      burst_pause  = BURST_PAUSE_RST;
      silent_pause = SILENT_PAUSE_RST;
      rng_phase    = RNG_TRIGGER;
      rng_count    = '0;
      rise_at      = '0;
      width_last   = '0;
      tone_last    = '0;
      tn_phase     = TONE_IDLE;
      tn_count     = '0;
      toggles      = '0;
      half_per     = '0;
      alarm        = 1'b0;
      expected_pins.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_TRIG_WIDTH:    trig_width   = cfg_mon.data[TRIG_W-1:0];
          CFG_ECHO_TIMEOUT:  echo_timeout = cfg_mon.data[TOUT_W-1:0];
          CFG_MEASURE_GAP:   meas_gap     = cfg_mon.data[CNT_W-1:0];
          CFG_BURST_TOGGLES: burst_count  = cfg_mon.data[TOG_W-1:0];
          CFG_BURST_PAUSE:   burst_pause  = cfg_mon.data[CNT_W-1:0];
          CFG_SILENT_PAUSE:  silent_pause = cfg_mon.data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) predict_tick(in_mon.echo_level);

      if (out_mon.valid && out_mon.ready) begin
        if (expected_pins.size() == 0) begin
          if (errors < 10)
            $display("result %0d arrived with no tick outstanding", results_seen);
          errors++;
        end else begin
          exp_r = expected_pins.pop_front();
          if (out_mon.trigger_out !== exp_r.trigger || out_mon.alarm_out !== exp_r.alarm ||
              out_mon.measure_done !== exp_r.done || out_mon.echo_width_us !== exp_r.width ||
              out_mon.tone_hz !== exp_r.tone) begin
            if (errors < 10)
              $display({"result %0d: expected trig=%0b alarm=%0b done=%0b width=%0d tone=%0d,",
                        " got trig=%0b alarm=%0b done=%0b width=%0d tone=%0d"},
                       results_seen, exp_r.trigger, exp_r.alarm, exp_r.done, exp_r.width,
                       exp_r.tone, out_mon.trigger_out, out_mon.alarm_out,
                       out_mon.measure_done, out_mon.echo_width_us, out_mon.tone_hz);
            errors++;
          end
        end
        results_seen++;
      end
    end
    // leftovers count as failures until they arrive
    pending_results <= expected_pins.size();
    failures        <= errors + expected_pins.size();
  end

endmodule

>>> test/ultrasonic_proximity_alarm_test.sv
// Top of the ultrasonic proximity alarm test: clock, reset, tick and register stimulus, verdict.
// Depends on upa_pkg, the channel interfaces, the block and ultrasonic_proximity_alarm_checker.
`timescale 1ns / 1ps

module ultrasonic_proximity_alarm_test;
  import upa_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;

  upa_in_if  in_bus();
  upa_out_if out_bus();
  upa_cfg_if cfg_bus();

  int pending_results;
  int failures;

  ultrasonic_proximity_alarm DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  ultrasonic_proximity_alarm_checker alarm_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .cfg_mon         (cfg_bus),
    .pending_results (pending_results),
    .failures        (failures)
  );

  always #5 clk = ~clk;

  // echo waveform generator state
  logic echo_lvl;
  int   run_left;
  int   lo_min, lo_max, hi_max, noise_pct;
  bit   near_limit;
  bit   gaps_on;

  int holds_asked = 0;
  int holds_done  = 0;
  int idle_cycles = 0;

  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // alternating low/high runs, with some random samples mixed in
  function automatic logic next_echo();
    if ($urandom_range(0, 99) < noise_pct) return logic'($urandom_range(0, 1));
    if (run_left == 0) begin
      echo_lvl = ~echo_lvl;
      if (echo_lvl)
        run_left = near_limit ? 873 + $urandom_range(0, 2) : $urandom_range(1, hi_max);
      else
        run_left = $urandom_range(lo_min, lo_max);
    end
    run_left--;
    return echo_lvl;
  endfunction

  task automatic send_tick(input logic lvl);
    int gap;
    gap = gaps_on ? random_pause() : 0;
    in_bus.valid      <= 1'b1;
    in_bus.echo_level <= lvl;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering ticks and wait until every result is back
  task automatic finish_batch();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic send_pattern(input logic [11:0] bits);
    for (int i = 0; i < 12; i++) send_tick(bits[i]);
    finish_batch();
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input int unsigned val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned tw, input int unsigned tout,
                          input int unsigned gap, input int unsigned tog,
                          input int unsigned bp, input int unsigned sp);
    cfg_write(CFG_TRIG_WIDTH, tw);
    cfg_write(CFG_ECHO_TIMEOUT, tout);
    cfg_write(CFG_MEASURE_GAP, gap);
    cfg_write(CFG_BURST_TOGGLES, tog);
    cfg_write(CFG_BURST_PAUSE, bp);
    cfg_write(CFG_SILENT_PAUSE, sp);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_ticks(input int n, input int lo_a, input int lo_b, input int hi_b,
                           input int noise, input bit near, input bit gaps);
    lo_min     = lo_a;
    lo_max     = lo_b;
    hi_max     = hi_b;
    noise_pct  = noise;
    near_limit = near;
    gaps_on    = gaps;
    run_left   = 0;
    for (int i = 0; i < n; i++) send_tick(next_echo());
    finish_batch();
  endtask

  // result side: ready runs and stalls, plus requested long hold-offs
  initial begin : result_sink
    int run, stall;
    forever begin
      if (holds_done < holds_asked) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        run = $urandom_range(1, 40);
        out_bus.ready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = random_pause();
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ultrasonic_proximity_alarm_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.echo_level <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_TRIG_WIDTH;
    cfg_bus.data      <= '0;
    echo_lvl   = 1'b0;
    run_left   = 0;
    noise_pct  = 0;
    near_limit = 1'b0;
    gaps_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: echo up through the trigger gives a one-tick pulse
    send_pattern(12'b0111_1111_1111);
    // all-zero settings: one-tick trigger, immediate timeouts, no gaps or pauses
    set_regs(0, 0, 0, 0, 0, 0);
    send_pattern(12'b1100_0101_1100);

    set_regs(1, 12, 3, 31, 2, 4);
    run_ticks(60, 1, 8, 10, 30, 1'b0, 1'b1);
    set_regs(255, 65535, 262143, 63, 262143, 262143);
    run_ticks(40, 1, 10, 10, 50, 1'b0, 1'b1);
    // long receiver hold while ticks keep coming
    set_regs(2, 40, 5, 1, 1, 3);
    holds_asked++;
    run_ticks(120, 2, 30, 30, 10, 1'b0, 1'b1);
    // short pulses: bursts, pauses, silent takes
    set_regs(1, 6, 0, 1, 0, 0);
    run_ticks(100, 2, 6, 4, 5, 1'b0, 1'b1);
    // long timeout, wider pulses, ticks back to back
    set_regs(0, 1000, 0, 2, 50, 20);
    run_ticks(60, 2, 10, 40, 0, 1'b0, 1'b0);
    set_regs(8, 1, 2, 5, 100, 60);
    run_ticks(50, 1, 3, 3, 60, 1'b0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ultrasonic_proximity_alarm_test: PASS");
    end else begin
      $display("ultrasonic_proximity_alarm_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/upa_pkg.sv
rtl/upa_in_if.sv
rtl/upa_out_if.sv
rtl/upa_cfg_if.sv
rtl/upa_div.sv
rtl/upa_ctrl.sv
rtl/upa_datapath.sv
rtl/ultrasonic_proximity_alarm.sv
test/ultrasonic_proximity_alarm_checker.sv
test/ultrasonic_proximity_alarm_test.sv
